@@ hw/rtl/software_timer_bank_defines.svh @@
// Assertion macros for the software timer bank.
// Included by the top level; expects clk and rst_n in the including scope.
`ifndef SOFTWARE_TIMER_BANK_DEFINES_SVH
`define SOFTWARE_TIMER_BANK_DEFINES_SVH
`ifndef SYNTH
`define STB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed: %m");
`define STB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed: %m");
`else
`define STB_ASSERT_IMP(lbl, ante, cons)
`define STB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/stb_pkg.sv @@
// Types, codes and the unit factor table of the software timer bank.
// No dependencies; used by stb_cell, software_timer_bank and the testbench.
`default_nettype none
package stb_pkg;

  // operation codes
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_REG    = 3'd1;
  localparam logic [2:0] OP_START  = 3'd2;
  localparam logic [2:0] OP_RESET  = 3'd3;
  localparam logic [2:0] OP_STOP   = 3'd4;
  localparam logic [2:0] OP_STATUS = 3'd5;

  // result kinds and status codes
  localparam logic       KIND_CMD    = 1'b0;
  localparam logic       KIND_EXPIRY = 1'b1;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOREG    = 2'd2;

  // time units
  localparam logic [3:0] UNIT_TICKS = 4'd0;
  localparam logic [3:0] UNIT_MS    = 4'd1;
  localparam logic [3:0] UNIT_SEC   = 4'd2;
  localparam logic [3:0] UNIT_MIN   = 4'd3;
  localparam logic [3:0] UNIT_HOUR  = 4'd4;
  localparam logic [3:0] UNIT_DAY   = 4'd5;
  localparam logic [3:0] UNIT_WEEK  = 4'd6;
  localparam logic [3:0] UNIT_MONTH = 4'd7;
  localparam logic [3:0] UNIT_YEAR  = 4'd8;

  // slot flag bit positions
  localparam int F_ACT = 0;
  localparam int F_EXP = 1;
  localparam int F_PAU = 2;
  localparam int F_INF = 3;

  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  slot;
    logic [31:0] time_value;
    logic [3:0]  time_unit;
    logic        infinite;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [3:0]  slot_out;
    logic [31:0] tick_count;
    logic [31:0] elapsed_out;
    logic [2:0]  flags_out;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [3:0]  flags;
    logic [31:0] elapsed;
    logic [31:0] limit;
  } slot_st_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] elapsed;
    logic [2:0]  flags;
  } expiry_t;

  typedef struct packed {
    logic [3:0]  slot;
    logic [31:0] elapsed;
    logic [2:0]  flags;
  } pend_t;

  // milliseconds per unit; the year does not fit and is handled apart
  function automatic logic [31:0] unit_factor(input logic [3:0] unit);
    logic [31:0] f;
    case (unit)
      UNIT_SEC:   f = 32'd1000;
      UNIT_MIN:   f = 32'd60000;
      UNIT_HOUR:  f = 32'd3600000;
      UNIT_DAY:   f = 32'd86400000;
      UNIT_WEEK:  f = 32'd604800000;
      UNIT_MONTH: f = 32'd2592000000;
      default:    f = 32'd1;
    endcase
    return f;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/stb_cell.sv @@
// One timer slot of the bank: flags, elapsed count and limit.
// Depends on stb_pkg. A tick token passes from cell to cell, one per cycle.
`default_nettype none
module stb_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tok_in,
  input  logic              wr_en,
  input  stb_pkg::slot_st_t wr_st,
  output logic              tok_out,
  output stb_pkg::slot_st_t st,
  output stb_pkg::expiry_t  exp_o
);
  import stb_pkg::*;

  logic        tok_r;
  slot_st_t    st_r, st_nxt;
  logic [31:0] el_inc;
  logic        run, fire;
  logic [3:0]  flags_new;

  // count up under the token, saturate, check the limit
  always_comb begin
    el_inc    = (st_r.elapsed == MAX32) ? st_r.elapsed : st_r.elapsed + 32'd1;
    run       = tok_r && st_r.flags[F_ACT] && !st_r.flags[F_PAU];
    fire      = run && !st_r.flags[F_INF] && (el_inc >= st_r.limit);
    flags_new = st_r.flags;
    if (fire) begin
      flags_new[F_ACT] = 1'b0;
      flags_new[F_EXP] = 1'b1;
    end
    st_nxt = st_r;
    if (wr_en) begin
      st_nxt = wr_st;
    end else if (run) begin
      st_nxt.elapsed = el_inc;
      st_nxt.flags   = flags_new;
    end
  end

  // hold slot state; only the flags need clearing at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r       <= 1'b0;
      st_r.flags  <= 4'd0;
    end else begin
      tok_r       <= tok_in;
      st_r.flags  <= st_nxt.flags;
    end
    st_r.elapsed <= st_nxt.elapsed;
    st_r.limit   <= st_nxt.limit;
  end

  assign tok_out       = tok_r;
  assign st            = st_r;
  assign exp_o.hit     = fire;
  assign exp_o.elapsed = el_inc;
  assign exp_o.flags   = flags_new[2:0];

endmodule
`default_nettype wire

@@ hw/rtl/software_timer_bank.sv @@
// Top level of the software timer bank: command decode, conversion, tick walk.
// Depends on stb_pkg, stb_cell and software_timer_bank_defines.svh.
//
// Usage: present a command word on in_word and raise start; it is taken at a
// rising edge where start is high and busy is low. Results leave on out_word,
// each for exactly one cycle with out_valid high; the receiver cannot stall,
// so every result must be taken in the cycle it appears.
// Register, stop, status and commands on an unregistered slot finish in the
// accepting cycle and their result shows the cycle after; unknown codes give
// no result. Start and reset pass through a multiply state (the 32x32 unit
// multiply) and a saturate state that writes the slot. A tick walks a token down
// the row of slot cells, one cell per cycle, and keeps busy high until the walk
// and its flush state end; expiry results stream out in ascending slot order,
// the last one marked by last.
// Reset: synchronous and active low; clears the tick counter, the slot count
// and every slot's flags, so no timer is active afterwards.
`default_nettype none
`include "software_timer_bank_defines.svh"
module software_timer_bank #(
  parameter int NUM_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  stb_pkg::in_word_t  in_word,
  output logic               out_valid,
  output stb_pkg::out_word_t out_word
);
  import stb_pkg::*;

  localparam int SLOT_CAP = (NUM_SLOTS < 16) ? NUM_SLOTS : 16;
  localparam int IDX_W    = (SLOT_CAP > 1) ? $clog2(SLOT_CAP) : 1;
  localparam int CNT_W    = $clog2(SLOT_CAP + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_SAT   = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [2:0]       state_r, state_nxt;
  in_word_t         cmd_r;
  logic [31:0]      tick_r, tick_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [63:0]      prod_r;
  logic             pend_v_r, pend_v_nxt;
  pend_t            pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_r, out_nxt;

  logic             accept;
  logic             slot_ok;
  logic             walk_go;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  slot_st_t         wr_st;
  logic [IDX_W-1:0] rd_idx;
  slot_st_t         rd_st;
  logic [31:0]      lim_conv;
  logic             hit;
  pend_t            hit_rec;

  slot_st_t         cell_st  [SLOT_CAP];
  expiry_t          cell_exp [SLOT_CAP];
  logic [SLOT_CAP-1:0] tok_v;

  // row of slot cells, token handed down the chain
  for (genvar i = 0; i < SLOT_CAP; i++) begin : g_cell
    logic tok_in_i;
    if (i == 0) begin : g_head
      assign tok_in_i = walk_go;
    end else begin : g_link
      assign tok_in_i = tok_v[i-1];
    end
    stb_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (tok_in_i),
      .wr_en   (wr_en && (wr_idx == IDX_W'(i))),
      .wr_st   (wr_st),
      .tok_out (tok_v[i]),
      .st      (cell_st[i]),
      .exp_o   (cell_exp[i])
    );
  end

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign slot_ok = ({1'b0, in_word.slot} < 5'(used_r));
  assign rd_idx  = (state_r == ST_IDLE) ? in_word.slot[IDX_W-1:0] : cmd_r.slot[IDX_W-1:0];
  assign rd_st   = cell_st[rd_idx];

  // saturate the product; a year of anything but zero overflows
  always_comb begin
    if (cmd_r.time_unit == UNIT_YEAR) begin
      lim_conv = (cmd_r.time_value == 32'd0) ? 32'd0 : MAX32;
    end else if (prod_r[63:32] != 32'd0) begin
      lim_conv = MAX32;
    end else begin
      lim_conv = prod_r[31:0];
    end
  end

  // pick the cell that expired under the token
  always_comb begin
    hit     = 1'b0;
    hit_rec = '0;
    for (int i = 0; i < SLOT_CAP; i++) begin
      if (cell_exp[i].hit) begin
        hit             = 1'b1;
        hit_rec.slot    = 4'(i);
        hit_rec.elapsed = cell_exp[i].elapsed;
        hit_rec.flags   = cell_exp[i].flags;
      end
    end
  end

  // decode commands and sequence the walk
  always_comb begin
    state_nxt     = state_r;
    tick_nxt      = tick_r;
    used_nxt      = used_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    walk_go       = 1'b0;
    wr_en         = 1'b0;
    wr_idx        = rd_idx;
    wr_st         = rd_st;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_nxt.kind        = KIND_CMD;
          out_nxt.status      = ST_OK;
          out_nxt.slot_out    = in_word.slot;
          out_nxt.tick_count  = tick_r;
          out_nxt.elapsed_out = 32'd0;
          out_nxt.flags_out   = 3'd0;
          out_nxt.last        = 1'b1;
          case (in_word.op)
            OP_TICK: begin
              tick_nxt   = tick_r + 32'd1;
              walk_go    = 1'b1;
              pend_v_nxt = 1'b0;
              state_nxt  = ST_WALK;
            end
            OP_REG: begin
              out_valid_nxt = 1'b1;
              if (used_r >= CNT_W'(SLOT_CAP)) begin
                out_nxt.status   = ST_FULL;
                out_nxt.slot_out = 4'd0;
              end else begin
                wr_en            = 1'b1;
                wr_idx           = used_r[IDX_W-1:0];
                wr_st            = '0;
                used_nxt         = used_r + CNT_W'(1);
                out_nxt.slot_out = 4'(used_r);
              end
            end
            OP_START, OP_RESET: begin
              if (slot_ok) begin
                state_nxt = ST_MUL;
              end else begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = ST_NOREG;
              end
            end
            OP_STOP: begin
              out_valid_nxt = 1'b1;
              if (slot_ok) begin
                wr_en                = 1'b1;
                wr_st.flags[F_ACT]   = 1'b0;
                wr_st.flags[F_PAU]   = 1'b1;
                out_nxt.elapsed_out  = rd_st.elapsed;
                out_nxt.flags_out    = wr_st.flags[2:0];
              end else begin
                out_nxt.status = ST_NOREG;
              end
            end
            OP_STATUS: begin
              out_valid_nxt = 1'b1;
              if (slot_ok) begin
                out_nxt.elapsed_out = rd_st.elapsed;
                out_nxt.flags_out   = rd_st.flags[2:0];
              end else begin
                out_nxt.status = ST_NOREG;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MUL: begin
        state_nxt = ST_SAT;
      end
      ST_SAT: begin
        wr_en         = 1'b1;
        wr_st.elapsed = 32'd0;
        if (cmd_r.op == OP_START) begin
          wr_st.flags        = 4'd0;
          wr_st.flags[F_ACT] = 1'b1;
          wr_st.flags[F_INF] = cmd_r.infinite;
          wr_st.limit        = cmd_r.infinite ? 32'd0 : lim_conv;
        end else begin
          wr_st.flags        = 4'd0;
          wr_st.flags[F_INF] = rd_st.flags[F_INF];
          wr_st.limit        = lim_conv;
        end
        out_valid_nxt       = 1'b1;
        out_nxt.kind        = KIND_CMD;
        out_nxt.status      = ST_OK;
        out_nxt.slot_out    = cmd_r.slot;
        out_nxt.tick_count  = tick_r;
        out_nxt.elapsed_out = 32'd0;
        out_nxt.flags_out   = wr_st.flags[2:0];
        out_nxt.last        = 1'b1;
        state_nxt           = ST_IDLE;
      end
      ST_WALK: begin
        // release the held expiry once a later one proves it is not the last
        if (hit) begin
          if (pend_v_r) begin
            out_valid_nxt       = 1'b1;
            out_nxt.kind        = KIND_EXPIRY;
            out_nxt.status      = ST_OK;
            out_nxt.slot_out    = pend_r.slot;
            out_nxt.tick_count  = tick_r;
            out_nxt.elapsed_out = pend_r.elapsed;
            out_nxt.flags_out   = pend_r.flags;
            out_nxt.last        = 1'b0;
          end
          pend_v_nxt = 1'b1;
          pend_nxt   = hit_rec;
        end
        if (tok_v[SLOT_CAP-1]) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (pend_v_r) begin
          out_valid_nxt       = 1'b1;
          out_nxt.kind        = KIND_EXPIRY;
          out_nxt.status      = ST_OK;
          out_nxt.slot_out    = pend_r.slot;
          out_nxt.tick_count  = tick_r;
          out_nxt.elapsed_out = pend_r.elapsed;
          out_nxt.flags_out   = pend_r.flags;
          out_nxt.last        = 1'b1;
        end
        pend_v_nxt = 1'b0;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_r      <= 32'd0;
      used_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      used_r      <= used_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers: command word, product, held expiry, result word
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_word;
    end
    prod_r <= {32'd0, cmd_r.time_value} * {32'd0, unit_factor(cmd_r.time_unit)};
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  `STB_ASSERT_IMP(a_tok_onehot, 1'b1, $onehot0(tok_v))
  `STB_ASSERT_IMP(a_used_cap, 1'b1, used_r <= CNT_W'(SLOT_CAP))
  `STB_ASSERT_NEXT(a_flush_idle, state_r == ST_FLUSH, state_r == ST_IDLE)
  `STB_ASSERT_IMP(a_expiry_walk, out_valid_r && (out_r.kind == KIND_EXPIRY), ($past(state_r) == ST_WALK) || ($past(state_r) == ST_FLUSH))

endmodule
`default_nettype wire

@@ tb/sv/software_timer_bank_checker.sv @@
// Scoreboard for the software timer bank: watches the command and result channels,
// keeps its own copy of the timer table and compares every result word.
// Depends on stb_pkg for the word types and the operation, status and unit codes.
`timescale 1ns / 1ps
module software_timer_bank_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  stb_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  stb_pkg::out_word_t out_word,
  output int                 fail_count,
  output int                 pending
);
  import stb_pkg::*;

  localparam int SLOTS = 16;

  // shadow of the timer table
  logic [31:0] ticks;
  logic [4:0]  used;
  logic [3:0]  flags   [SLOTS];
  logic [31:0] elapsed [SLOTS];
  logic [31:0] limit   [SLOTS];

  out_word_t awaited [$];
  int        mismatches = 0;

  // duration in ms, saturated at 32 bits; unknown units count as ms
  function automatic logic [31:0] to_ms(input logic [31:0] value, input logic [3:0] unit);
    logic [35:0] f;
    logic [67:0] prod;
    case (unit)
      UNIT_SEC:   f = 36'd1000;
      UNIT_MIN:   f = 36'd60000;
      UNIT_HOUR:  f = 36'd3600000;
      UNIT_DAY:   f = 36'd86400000;
      UNIT_WEEK:  f = 36'd604800000;
      UNIT_MONTH: f = 36'd2592000000;
      UNIT_YEAR:  f = 36'd31536000000;
      default:    f = 36'd1;
    endcase
    prod = {36'd0, value} * {32'd0, f};
    return (prod > {36'd0, MAX32}) ? MAX32 : prod[31:0];
  endfunction

  function automatic out_word_t result_word(input logic kind, input logic [1:0] status,
                                            input logic [3:0] slot, input logic [31:0] el,
                                            input logic [2:0] fl, input logic fin);
    out_word_t r;
    r.kind        = kind;
    r.status      = status;
    r.slot_out    = slot;
    r.tick_count  = ticks;
    r.elapsed_out = el;
    r.flags_out   = fl;
    r.last        = fin;
    return r;
  endfunction

  // apply one command word to the shadow table and queue the words it causes
  task automatic run_timer_cmd(input in_word_t w);
    logic [3:0] f;
    logic [3:0] s;
    logic       have;
    out_word_t  held;
    have = 1'b0;
    held = '0;
    s    = w.slot;
    case (w.op)
      OP_TICK: begin
        ticks = ticks + 32'd1;
        for (int i = 0; i < used; i++) begin
          f = flags[i];
          if (f[F_ACT] && !f[F_PAU]) begin
            if (elapsed[i] != MAX32) elapsed[i] = elapsed[i] + 32'd1;
            if (!f[F_INF] && elapsed[i] >= limit[i]) begin
              f[F_ACT] = 1'b0;
              f[F_EXP] = 1'b1;
              flags[i] = f;
              // hold each expiry back one slot so the final one can be marked
              if (have) awaited.push_back(held);
              held = result_word(KIND_EXPIRY, ST_OK, 4'(i), elapsed[i], f[2:0], 1'b0);
              have = 1'b1;
            end
          end
        end
        if (have) begin
          held.last = 1'b1;
          awaited.push_back(held);
        end
      end
      OP_REG: begin
        if (used >= 5'(SLOTS)) begin
          awaited.push_back(result_word(KIND_CMD, ST_FULL, 4'd0, 32'd0, 3'd0, 1'b1));
        end else begin
          flags[used]   = 4'd0;
          elapsed[used] = 32'd0;
          limit[used]   = 32'd0;
          awaited.push_back(result_word(KIND_CMD, ST_OK, used[3:0], 32'd0, 3'd0, 1'b1));
          used = used + 5'd1;
        end
      end
      OP_START, OP_RESET, OP_STOP, OP_STATUS: begin
        if ({1'b0, s} >= used) begin
          awaited.push_back(result_word(KIND_CMD, ST_NOREG, s, 32'd0, 3'd0, 1'b1));
        end else begin
          if (w.op == OP_START) begin
            elapsed[s] = 32'd0;
            flags[s]   = 4'd0;
            flags[s][F_ACT] = 1'b1;
            flags[s][F_INF] = w.infinite;
            limit[s]   = w.infinite ? 32'd0 : to_ms(w.time_value, w.time_unit);
          end else if (w.op == OP_RESET) begin
            // keep only the infinite mark
            flags[s][F_ACT] = 1'b0;
            flags[s][F_EXP] = 1'b0;
            flags[s][F_PAU] = 1'b0;
            elapsed[s] = 32'd0;
            limit[s]   = to_ms(w.time_value, w.time_unit);
          end else if (w.op == OP_STOP) begin
            flags[s][F_ACT] = 1'b0;
            flags[s][F_PAU] = 1'b1;
          end
          awaited.push_back(result_word(KIND_CMD, ST_OK, s, elapsed[s], flags[s][2:0], 1'b1));
        end
      end
      default: begin
        // unknown codes are dropped without a result
      end
    endcase
  endtask

  task automatic note_failure(input string what, input out_word_t e, input out_word_t g);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected kind %0d status %0d slot %0d ticks %0d elapsed %0d flags %0d last %0d",
               what, e.kind, e.status, e.slot_out, e.tick_count, e.elapsed_out, e.flags_out,
               e.last);
    if (mismatches <= 10)
      $display("  got kind %0d status %0d slot %0d ticks %0d elapsed %0d flags %0d last %0d",
               g.kind, g.status, g.slot_out, g.tick_count, g.elapsed_out, g.flags_out, g.last);
  endtask

  // results first: a word leaving now belongs to an earlier command
  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      ticks = 32'd0;
      used  = 5'd0;
      for (int i = 0; i < SLOTS; i++) begin
        flags[i]   = 4'd0;
        elapsed[i] = 32'd0;
        limit[i]   = 32'd0;
      end
      awaited.delete();
    end else begin
      if (out_valid) begin
        if (awaited.size() == 0) begin
          note_failure("unexpected result word", '0, out_word);
        end else begin
          e = awaited.pop_front();
          if (e.kind !== out_word.kind || e.status !== out_word.status ||
              e.slot_out !== out_word.slot_out || e.tick_count !== out_word.tick_count ||
              e.elapsed_out !== out_word.elapsed_out || e.flags_out !== out_word.flags_out ||
              e.last !== out_word.last)
            note_failure("result word mismatch", e, out_word);
        end
      end
      if (start && !busy) run_timer_cmd(in_word);
    end
    pending    <= awaited.size();
    fail_count <= mismatches;
  end

endmodule

@@ tb/sv/software_timer_bank_test.sv @@
// Top of the software timer bank testbench: clock, reset, command stimulus and verdict.
// Depends on stb_pkg, software_timer_bank and software_timer_bank_checker.
`timescale 1ns / 1ps
module software_timer_bank_test;
  import stb_pkg::*;

  // a tick holds busy only through its walk and a sender gap is bounded, so STALL_LIMIT
  // quiet cycles can only mean a hang
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 440;
  localparam int DRAIN_CYCLES = 40;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_valid;
  out_word_t out_word;
  int        fail_count;
  int        pending;
  int        idle_cycles = 0;
  int        reg_count = 0;
  int        calm_left = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  software_timer_bank #(
    .NUM_SLOTS(16)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  software_timer_bank_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // count cycles in which no word moves on either channel
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_word_t cmd(input logic [2:0] op, input logic [3:0] slot,
                                   input logic [31:0] value, input logic [3:0] unit,
                                   input logic inf);
    in_word_t w;
    w.op         = op;
    w.slot       = slot;
    w.time_value = value;
    w.time_unit  = unit;
    w.infinite   = inf;
    return w;
  endfunction

  // present one command word after a random gap and hold it until taken
  task automatic issue_word(input in_word_t w);
    int gap;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 14);
      if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (w.op == OP_REG) reg_count++;
  endtask

  initial begin
    in_word_t    w;
    int          items;
    int          regs;
    int          pick;
    int          k;
    logic [31:0] v;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_word = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: unregistered slots, zero limit, infinite, pause, every unit, saturation
    issue_word(cmd(OP_STATUS, 4'd0, 32'hFFFF_FFFF, 4'd15, 1'b1));
    issue_word(cmd(OP_START, 4'd15, 32'd5, UNIT_MS, 1'b0));
    issue_word(cmd(OP_REG, 4'd15, 32'd0, 4'd0, 1'b0));
    issue_word(cmd(OP_REG, 4'd0, 32'd0, 4'd0, 1'b0));
    issue_word(cmd(OP_START, 4'd0, 32'd0, UNIT_TICKS, 1'b0));
    issue_word(cmd(OP_START, 4'd1, 32'd2, UNIT_MS, 1'b1));
    issue_word(cmd(OP_TICK, 4'd0, 32'd0, 4'd0, 1'b0));
    issue_word(cmd(OP_TICK, 4'd0, 32'd0, 4'd0, 1'b0));
    issue_word(cmd(OP_STATUS, 4'd1, 32'd0, 4'd0, 1'b0));
    issue_word(cmd(OP_STOP, 4'd1, 32'd0, 4'd0, 1'b0));
    issue_word(cmd(OP_TICK, 4'd0, 32'd0, 4'd0, 1'b0));
    issue_word(cmd(OP_RESET, 4'd1, 32'd3, 4'd15, 1'b0));
    issue_word(cmd(OP_START, 4'd1, 32'd2, 4'd9, 1'b0));
    issue_word(cmd(OP_TICK, 4'd0, 32'd0, 4'd0, 1'b0));
    issue_word(cmd(OP_TICK, 4'd0, 32'd0, 4'd0, 1'b0));
    issue_word(cmd(OP_START, 4'd0, 32'hFFFF_FFFF, UNIT_YEAR, 1'b0));
    issue_word(cmd(OP_START, 4'd0, 32'd1, UNIT_SEC, 1'b0));
    issue_word(cmd(OP_RESET, 4'd0, 32'hFFFF_FFFF, UNIT_MONTH, 1'b0));
    issue_word(cmd(OP_START, 4'd0, 32'd4, UNIT_MIN, 1'b0));
    issue_word(cmd(OP_RESET, 4'd1, 32'd7, UNIT_DAY, 1'b1));
    issue_word(cmd(OP_START, 4'd1, 32'd3, UNIT_WEEK, 1'b0));
    issue_word(cmd(OP_START, 4'd0, 32'd2, UNIT_HOUR, 1'b0));
    issue_word(cmd(3'd6, 4'd15, 32'hFFFF_FFFF, 4'd15, 1'b1));
    issue_word(cmd(3'd7, 4'd0, 32'd0, 4'd0, 1'b0));
    issue_word(cmd(OP_TICK, 4'd15, 32'hFFFF_FFFF, 4'd15, 1'b1));

    // random: mostly valid commands on registered slots, with noise around them
    items = 0;
    while (items < RANDOM_ITEMS) begin
      regs = (reg_count < 16) ? reg_count : 16;
      w.op         = 3'($urandom);
      w.slot       = 4'($urandom);
      w.time_value = $urandom;
      w.time_unit  = 4'($urandom);
      w.infinite   = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 4 && regs > 0) begin
        // arm every registered timer alike, so many expire on one tick
        v = $urandom_range(0, 3);
        for (int i = 0; i < regs; i++) begin
          issue_word(cmd(OP_START, 4'(i), v, UNIT_TICKS, 1'b0));
          items++;
        end
      end else if (pick < 8) begin
        w.op = 3'($urandom_range(6, 7));
        issue_word(w);
        items++;
      end else begin
        if (pick < 40)      w.op = OP_TICK;
        else if (pick < 50) w.op = OP_REG;
        else if (pick < 72) w.op = OP_START;
        else if (pick < 80) w.op = OP_RESET;
        else if (pick < 88) w.op = OP_STOP;
        else                w.op = OP_STATUS;
        if (regs > 0 && $urandom_range(0, 9) < 8) w.slot = 4'($urandom_range(0, regs - 1));
        k = $urandom_range(0, 9);
        if (k < 6) begin
          w.time_value = $urandom_range(0, 12);
          w.time_unit  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15))
                                                     : 4'($urandom_range(0, 1));
        end else if (k > 7) begin
          w.time_value = $urandom_range(0, 3);
        end
        w.infinite = ($urandom_range(0, 6) == 0);
        issue_word(w);
        items++;
      end
    end
    start <= 1'b0;

    // drain: let the last tick finish its walk
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
